FILE: sv/framed_packet_receiver_macros.svh
// assertion macros shared by the framed packet receiver modules
`ifndef FRAMED_PACKET_RECEIVER_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define FPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fpr_pkg.sv
// shared types and constants of the framed packet receiver
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ADDR_W   = 2;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [ADDR_W-1:0]   t_reg_addr;

    // result status codes
    localparam t_status ST_NONE   = 3'd0;
    localparam t_status ST_DATA   = 3'd1;
    localparam t_status ST_GOOD   = 3'd2;
    localparam t_status ST_SUMERR = 3'd3;
    localparam t_status ST_TOOBIG = 3'd4;
    localparam t_status ST_ZERO   = 3'd5;

    // configuration register indexes
    localparam t_reg_addr REG_SYNC_FIRST  = 2'd0;
    localparam t_reg_addr REG_SYNC_SECOND = 2'd1;
    localparam t_reg_addr REG_MAX_LENGTH  = 2'd2;

    // configuration reset values
    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'hAB;
    localparam logic [BYTE_W-1:0] RST_MAX_LENGTH  = 8'd250;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] max_length;
    } t_cfg;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] frame_number;
        logic [BYTE_W-1:0] frame_length;
    } t_result;

endpackage

FILE: sv/framed_packet_receiver.sv
// top level of the framed packet receiver
`timescale 1ns / 1ps
// usage:
//   s_axis carries one received byte per item in s_axis_tdata[7:0]
//   m_axis gives exactly one result per accepted byte: tuser holds the status
//     (0 nothing, 1 payload byte, 2 frame good, 3 checksum error,
//     4 length too big, 5 zero length), tdata the payload byte, frame number
//     and frame length
//   frame layout: sync_first, sync_second, channel byte, length L (counts
//     itself plus payload), L-1 payload bytes, 8-bit sum of L and payload
//   config port: i_cfg_we with i_cfg_addr 0 sync_first, 1 sync_second,
//     2 max_length; other indexes are ignored; write only while idle
//   output: a result reaches m_axis from the result register (via skid if stalled)
//   throughput: one byte per cycle while the skid register is empty; the parser
//     state and running checksum update on every accepted byte
//   stall: a two-deep output stage (result register plus skid) keeps taking
//     one more byte after m_axis_tready drops; s_axis_tready falls only once
//     the skid register is occupied
//   reset (synchronous, active low): parser back to header hunt, frame counter
//     zero, sync bytes 0xAA 0xAB, max length 250, output stage empty

module framed_packet_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // rx_byte[7:0]
    input  logic [7:0]                    s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // data_byte[7:0], frame_number[15:8], frame_length[23:16]
    output logic [23:0]                   m_axis_tdata,
    // status[2:0]
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          i_cfg_we,
    input  fpr_pkg::t_reg_addr            i_cfg_addr,
    input  logic [fpr_pkg::BYTE_W-1:0]    i_cfg_wdata
);

    fpr_pkg::t_cfg    cfg;
    fpr_pkg::t_result parse_res;
    fpr_pkg::t_result out_res;
    logic             in_accept;
    logic             skid_ready;

    assign in_accept     = s_axis_tvalid && skid_ready;
    assign s_axis_tready = skid_ready;

    fpr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // state advances only on an accepted byte
    fpr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_accept),
        .i_byte   (s_axis_tdata),
        .i_cfg    (cfg),
        .o_result (parse_res)
    );

    fpr_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (skid_ready),
        .i_result (parse_res),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    assign m_axis_tdata = {out_res.frame_length, out_res.frame_number, out_res.data_byte};
    assign m_axis_tuser = out_res.status;

endmodule

FILE: sv/fpr_cfg_regs.sv
// configuration registers of the framed packet receiver
`timescale 1ns / 1ps

module fpr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  fpr_pkg::t_reg_addr            i_addr,
    input  logic [fpr_pkg::BYTE_W-1:0]    i_wdata,
    output fpr_pkg::t_cfg                 o_cfg
);

    fpr_pkg::t_cfg r_cfg;
    fpr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_addr)
                fpr_pkg::REG_SYNC_FIRST:  n_cfg.sync_first  = i_wdata;
                fpr_pkg::REG_SYNC_SECOND: n_cfg.sync_second = i_wdata;
                fpr_pkg::REG_MAX_LENGTH:  n_cfg.max_length  = i_wdata;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= fpr_pkg::RST_SYNC_FIRST;
            r_cfg.sync_second <= fpr_pkg::RST_SYNC_SECOND;
            r_cfg.max_length  <= fpr_pkg::RST_MAX_LENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/fpr_parser.sv
// frame parser state machine: one byte in, one result out
`timescale 1ns / 1ps
`include "framed_packet_receiver_macros.svh"

module fpr_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [fpr_pkg::BYTE_W-1:0]    i_byte,
    input  fpr_pkg::t_cfg                 i_cfg,
    output fpr_pkg::t_result              o_result
);

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_CHAN  = 3'd2,
        PH_LEN   = 3'd3,
        PH_BODY  = 3'd4
    } t_phase;

    t_phase                      r_phase,     n_phase;
    logic [fpr_pkg::BYTE_W-1:0]  r_byte_idx,  n_byte_idx;
    logic [fpr_pkg::BYTE_W-1:0]  r_exp_len,   n_exp_len;
    logic [fpr_pkg::BYTE_W-1:0]  r_sum,       n_sum;
    logic [fpr_pkg::BYTE_W-1:0]  r_frame_cnt, n_frame_cnt;

    logic [fpr_pkg::BYTE_W-1:0]  cur_frame;
    logic [fpr_pkg::BYTE_W:0]    idx_next;
    fpr_pkg::t_result            res;

    // frame number of the frame in flight, counter already advanced
    assign cur_frame = r_frame_cnt - 8'd1;
    assign idx_next  = {1'b0, r_byte_idx} + 9'd1;

    always_comb begin
        n_phase     = r_phase;
        n_byte_idx  = r_byte_idx;
        n_exp_len   = r_exp_len;
        n_sum       = r_sum;
        n_frame_cnt = r_frame_cnt;
        res         = '0;
        res.status  = fpr_pkg::ST_NONE;
        case (r_phase)
            PH_HUNT2: begin
                n_phase = (i_byte == i_cfg.sync_second) ? PH_CHAN : PH_HUNT1;
            end
            PH_CHAN: begin
                res.frame_number = r_frame_cnt;
                n_frame_cnt      = r_frame_cnt + 8'd1;
                n_phase          = PH_LEN;
            end
            PH_LEN: begin
                res.frame_number = cur_frame;
                res.frame_length = i_byte;
                n_exp_len        = i_byte;
                n_byte_idx       = '0;
                n_sum            = i_byte;
                if (i_byte > i_cfg.max_length) begin
                    res.status = fpr_pkg::ST_TOOBIG;
                    n_phase    = PH_HUNT1;
                end else begin
                    n_phase    = PH_BODY;
                end
            end
            PH_BODY: begin
                res.frame_number = cur_frame;
                res.frame_length = r_exp_len;
                if (r_exp_len == '0) begin
                    res.status = fpr_pkg::ST_ZERO;
                    n_phase    = PH_HUNT1;
                end else if (idx_next < {1'b0, r_exp_len}) begin
                    res.status    = fpr_pkg::ST_DATA;
                    res.data_byte = i_byte;
                    n_sum         = r_sum + i_byte;
                    n_byte_idx    = idx_next[fpr_pkg::BYTE_W-1:0];
                end else begin
                    res.status = (r_sum == i_byte) ? fpr_pkg::ST_GOOD : fpr_pkg::ST_SUMERR;
                    n_phase    = PH_HUNT1;
                end
            end
            default: begin
                n_phase = (i_byte == i_cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT1;
            r_byte_idx  <= '0;
            r_exp_len   <= '0;
            r_sum       <= '0;
            r_frame_cnt <= '0;
        end else if (i_valid) begin
            r_phase     <= n_phase;
            r_byte_idx  <= n_byte_idx;
            r_exp_len   <= n_exp_len;
            r_sum       <= n_sum;
            r_frame_cnt <= n_frame_cnt;
        end
    end

    assign o_result = res;

    `FPR_ASSERT_NEXT(a_cnt_step, i_valid && r_phase == PH_CHAN, r_frame_cnt == $past(r_frame_cnt) + 8'd1, "frame counter did not advance on channel byte")
    `FPR_ASSERT_NOW(a_idx_bound, r_phase == PH_BODY && r_exp_len != '0, r_byte_idx < r_exp_len, "payload index ran past frame length")
    `FPR_ASSERT_NOW(a_data_zero, o_result.status != fpr_pkg::ST_DATA, o_result.data_byte == '0, "data byte set without payload status")

endmodule

FILE: sv/fpr_out_skid.sv
// result register with skid stage for the output stream
`timescale 1ns / 1ps
`include "framed_packet_receiver_macros.svh"

module fpr_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fpr_pkg::t_result  i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output fpr_pkg::t_result  o_result
);

    logic             r_out_valid,  n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    fpr_pkg::t_result r_out,        n_out;
    fpr_pkg::t_result r_skid,       n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // input is held off; drain skid into the output register
            if (i_ready) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || i_ready) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `FPR_ASSERT_NOW(a_skid_has_out, r_skid_valid, r_out_valid, "skid holds an item while output is empty")
    `FPR_ASSERT_NEXT(a_skid_fill, i_valid && o_ready && r_out_valid && !i_ready, r_skid_valid, "stalled item was not caught in skid")
    `FPR_ASSERT_NEXT(a_out_hold, r_out_valid && !i_ready, r_out_valid && r_out == $past(r_out), "output item changed while stalled")

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the framed packet receiver
`timescale 1ns / 1ps

module testbench;

    // index past the last register, writes there must be dropped
    localparam fpr_pkg::t_reg_addr REG_UNUSED = 2'd3;

    // cycles without any accepted item or register write before the run is declared hung
    localparam int unsigned HANG_LIMIT = 300;
    // cycles to wait after the last result before touching config or ending
    localparam int unsigned SETTLE_CYCLES = 4;

    // parser phases of the local frame tracker
    typedef enum logic [2:0] {
        HUNT_FIRST  = 3'd0,
        HUNT_SECOND = 3'd1,
        CHANNEL     = 3'd2,
        LENGTH      = 3'd3,
        BODY        = 3'd4
    } t_rx_phase;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic [7:0]         s_axis_tdata = 8'd0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        m_axis_tdata;
    logic [2:0]         m_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic               i_cfg_we = 1'b0;
    fpr_pkg::t_reg_addr i_cfg_addr = fpr_pkg::REG_SYNC_FIRST;
    logic [7:0]         i_cfg_wdata = 8'd0;

    framed_packet_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the parser: register settings and frame state
    fpr_pkg::t_cfg cfg_model;
    t_rx_phase     rx_phase;
    logic [7:0]    payload_count;
    logic [7:0]    frame_len;
    logic [7:0]    check_sum;
    logic [7:0]    frames_started;

    // statuses still owed by the block, oldest first
    fpr_pkg::t_result expected_results[$];

    int  mismatches = 0;
    int  bytes_sent = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  src_gaps_on = 1'b0;
    bit  sink_stalls_on = 1'b0;

    // one received byte through the frame tracker, gives the status it must produce
    function automatic fpr_pkg::t_result parse_byte(input logic [7:0] b);
        fpr_pkg::t_result r;
        logic [7:0]       cur;
        r = '0;
        r.status = fpr_pkg::ST_NONE;
        cur = frames_started - 8'd1;
        case (rx_phase)
            HUNT_SECOND: begin
                // a wrong second byte is never retried as a first header byte
                rx_phase = (b == cfg_model.sync_second) ? CHANNEL : HUNT_FIRST;
            end
            CHANNEL: begin
                // channel byte itself is dropped, the frame takes its number
                r.frame_number = frames_started;
                frames_started = frames_started + 8'd1;
                rx_phase = LENGTH;
            end
            LENGTH: begin
                r.frame_number = cur;
                r.frame_length = b;
                frame_len = b;
                payload_count = 8'd0;
                check_sum = b;
                if (b > cfg_model.max_length) begin
                    r.status = fpr_pkg::ST_TOOBIG;
                    rx_phase = HUNT_FIRST;
                end else begin
                    rx_phase = BODY;
                end
            end
            BODY: begin
                r.frame_number = cur;
                r.frame_length = frame_len;
                if (frame_len == 8'd0) begin
                    // zero length eats one byte and aborts
                    r.status = fpr_pkg::ST_ZERO;
                    rx_phase = HUNT_FIRST;
                end else if ({1'b0, payload_count} + 9'd1 < {1'b0, frame_len}) begin
                    r.status = fpr_pkg::ST_DATA;
                    r.data_byte = b;
                    check_sum = check_sum + b;
                    payload_count = payload_count + 8'd1;
                end else begin
                    r.status = (check_sum == b) ? fpr_pkg::ST_GOOD : fpr_pkg::ST_SUMERR;
                    rx_phase = HUNT_FIRST;
                end
            end
            default: begin
                rx_phase = (b == cfg_model.sync_first) ? HUNT_SECOND : HUNT_FIRST;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic compare_field(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) report_mismatch(what, {24'd0, got}, {24'd0, want});
    endtask

    // result checker: every accepted status against the oldest pending one
    always @(posedge i_clk) begin : check_results
        fpr_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", {29'd0, m_axis_tuser}, 32'd0);
            end else begin
                want = expected_results.pop_front();
                compare_field("status", {5'd0, m_axis_tuser}, {5'd0, want.status});
                compare_field("data_byte", m_axis_tdata[7:0], want.data_byte);
                compare_field("frame_number", m_axis_tdata[15:8], want.frame_number);
                compare_field("frame_length", m_axis_tdata[23:16], want.frame_length);
            end
        end
    end

    // hang detector: any accepted item or register write counts as progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // output side backpressure, random stall bursts on m_axis_tready
    always @(negedge i_clk) begin
        if (!sink_stalls_on) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one byte into s_axis, with an optional gap first; tracked once accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(parse_byte(b));
        bytes_sent++;
    endtask

    // drop valid, let every owed status arrive, then wait SETTLE_CYCLES more
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only called while the block is idle
    task automatic set_register(input fpr_pkg::t_reg_addr addr, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (addr)
            fpr_pkg::REG_SYNC_FIRST:  cfg_model.sync_first = value;
            fpr_pkg::REG_SYNC_SECOND: cfg_model.sync_second = value;
            fpr_pkg::REG_MAX_LENGTH:  cfg_model.max_length = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // filler bytes until the parser hunts for a header again
    task automatic flush_to_hunt();
        logic [7:0] b;
        while (rx_phase != HUNT_FIRST) begin
            do b = 8'($urandom_range(0, 255));
            while (b == cfg_model.sync_first || b == cfg_model.sync_second);
            send_byte(b);
        end
    endtask

    // a whole frame under the current sync bytes, optionally with a bad checksum
    task automatic send_frame(input logic [7:0] len, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        send_byte(cfg_model.sync_first);
        send_byte(cfg_model.sync_second);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(len);
        sum = len;
        // an over-limit length ends the frame on the length byte
        if (len > cfg_model.max_length) return;
        if (len == 8'd0) begin
            send_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat (int'(len) - 1) begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
        end
        if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    // reset settings: length one, wrong second header, too long, payload extremes
    task automatic test_default_frames();
        // length one, checksum must be 1
        send_byte(8'hAA); send_byte(8'hAB); send_byte(8'h07); send_byte(8'h01);
        send_byte(8'h01);
        // repeated first header byte is taken as a bad second one
        send_byte(8'hAA); send_byte(8'hAA); send_byte(8'hAB);
        // 251 is one over the reset limit
        send_byte(8'hAA); send_byte(8'hAB); send_byte(8'h00); send_byte(8'hFB);
        // payload 0xff and 0x00, sum wraps to 0x02
        send_byte(8'hAA); send_byte(8'hAB); send_byte(8'hFF); send_byte(8'h03);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'h02);
        wait_idle();
    endtask

    // register extremes: ignored index, sync 0x00 0xff, max length zero
    task automatic test_register_extremes();
        set_register(REG_UNUSED, 8'h00);
        set_register(REG_UNUSED, 8'hFF);
        set_register(fpr_pkg::REG_SYNC_FIRST, 8'h00);
        set_register(fpr_pkg::REG_SYNC_SECOND, 8'hFF);
        set_register(fpr_pkg::REG_MAX_LENGTH, 8'h00);
        // zero length passes a limit of zero, then the next byte aborts it
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A); send_byte(8'h00);
        send_byte(8'hC3);
        // length one is already too long
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h11); send_byte(8'h01);
        wait_idle();
    endtask

    // phases of random settings and mostly well-formed random frames
    task automatic test_random_traffic(input int budget, input bit quiet);
        int         start;
        int         phase_start;
        int         kind;
        int         r;
        logic [7:0] f;
        logic [7:0] s;
        logic [7:0] m;
        logic [7:0] len;
        logic [7:0] b;
        bit         force_long;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            f = 8'($urandom_range(0, 255));
            s = ($urandom_range(0, 3) == 0) ? f : 8'($urandom_range(0, 255));
            r = $urandom_range(0, 9);
            if (r < 2) m = 8'd255;
            else if (r == 2) m = 8'd0;
            else if (r == 3) m = 8'd250;
            else m = 8'($urandom_range(1, 16));
            set_register(fpr_pkg::REG_SYNC_FIRST, f);
            set_register(fpr_pkg::REG_SYNC_SECOND, s);
            set_register(fpr_pkg::REG_MAX_LENGTH, m);
            if ($urandom_range(0, 3) == 0) set_register(REG_UNUSED, 8'($urandom_range(0, 255)));
            src_gaps_on = !quiet && ($urandom_range(0, 3) != 0);
            sink_stalls_on = !quiet && ($urandom_range(0, 3) != 0);
            // one full-size frame when the limit allows it
            force_long = (m == 8'd255);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 150 && bytes_sent - start < budget) begin
                kind = $urandom_range(0, 19);
                if (kind < 2) begin
                    // line noise, may leave the parser anywhere
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                end else if (kind < 4) begin
                    // broken header, often a repeated first byte
                    flush_to_hunt();
                    send_byte(f);
                    if (f != s && $urandom_range(0, 1) == 0) b = f;
                    else begin
                        do b = 8'($urandom_range(0, 255)); while (b == s);
                    end
                    send_byte(b);
                end else begin
                    flush_to_hunt();
                    r = $urandom_range(0, 29);
                    if (force_long) begin
                        len = 8'd255;
                        force_long = 1'b0;
                    end else if (r == 0) len = 8'($urandom_range(0, 255));
                    else if (r == 1) len = m;
                    else if (r == 2) len = m + 8'd1;
                    else len = 8'($urandom_range(0, 8));
                    send_frame(len, $urandom_range(0, 6) == 0);
                end
            end
            wait_idle();
        end
    endtask

    // shortest frames until the frame number has wrapped past 255
    task automatic test_frame_counter_wrap();
        int         n;
        logic [7:0] m;
        m = 8'($urandom_range(0, 127));
        set_register(fpr_pkg::REG_MAX_LENGTH, m);
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        n = 259 - int'(frames_started);
        repeat (n) begin
            flush_to_hunt();
            send_frame(8'($urandom_range(int'(m) + 1, 255)), 1'b0);
        end
        wait_idle();
    endtask

    initial begin
        cfg_model.sync_first = fpr_pkg::RST_SYNC_FIRST;
        cfg_model.sync_second = fpr_pkg::RST_SYNC_SECOND;
        cfg_model.max_length = fpr_pkg::RST_MAX_LENGTH;
        rx_phase = HUNT_FIRST;
        payload_count = 8'd0;
        frame_len = 8'd0;
        check_sum = 8'd0;
        frames_started = 8'd0;

        // single reset at the start of the run
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_frames();
        test_register_extremes();
        test_random_traffic(250, 1'b0);
        test_frame_counter_wrap();
        // closing stretch with no gaps or stalls on either side
        test_random_traffic(80, 1'b1);

        if (expected_results.size() != 0)
            report_mismatch("results missing", 32'(expected_results.size()), 32'd0);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
